[rtl/core/video_payload_packetizer_defines.svh]
// ----------------------------------------------------------------------------
// video payload packetizer assertion macros
// concurrent assertion shorthands for the packetizer core, used by vpp_queue
// ----------------------------------------------------------------------------
`ifndef VIDEO_PAYLOAD_PACKETIZER_DEFINES_SVH
`define VIDEO_PAYLOAD_PACKETIZER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define VPP_ASSERT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define VPP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/vpp_pkg.sv]
// ----------------------------------------------------------------------------
// vpp_pkg
// types, codes and constants shared by the payload packetizer modules
// ----------------------------------------------------------------------------
package vpp_pkg;

    localparam int SERIAL_BITS_DEF = 8;
    localparam int LENGTH_BITS_DEF = 24;
    localparam int QUEUE_DEPTH     = 4;

    localparam int OPCODE_W   = 2;
    localparam int FLEN_W     = 24;
    localparam int BYTE_W     = 8;
    localparam int TAG_W      = 8;
    localparam int REQ_W      = 16;
    localparam int PAYLOAD_W  = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    // input opcodes
    localparam logic [OPCODE_W-1:0] OP_FRAME_START = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DATA        = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOSS        = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_LOSSY   = 2'd2;

    localparam logic [REQ_W-1:0]     REQUEST_SIZE_RST = 16'd1024;
    localparam logic [PAYLOAD_W-1:0] MAX_PAYLOAD_RST  = 21'd0;
    localparam logic                 DROP_LOSSY_RST   = 1'b1;

    // payload header
    localparam logic [BYTE_W-1:0] HDR_LEN = 8'd2;
    localparam logic [BYTE_W-1:0] HDR_EOH = 8'h80;
    localparam logic [BYTE_W-1:0] HDR_ERR = 8'h40;
    localparam logic [BYTE_W-1:0] HDR_EOF = 8'h02;

    typedef struct packed {
        logic [REQ_W-1:0]     request_size;
        logic [PAYLOAD_W-1:0] max_payload;
        logic                 drop_lossy;
    } cfg_t;

    // everything the back end needs to emit the beats of one input item
    typedef struct packed {
        logic              hdr;
        logic [BYTE_W-1:0] hdr_flags;
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
        logic              full;
        logic [TAG_W-1:0]  tag;
        logic              discard;
        logic              aband;
    } group_t;

    typedef enum logic [2:0] {
        BEAT_HDR_LEN   = 3'b001,
        BEAT_HDR_FLAGS = 3'b010,
        BEAT_DATA      = 3'b100
    } beat_t;

endpackage

[rtl/core/video_payload_packetizer.sv]
// ----------------------------------------------------------------------------
// video_payload_packetizer
// cuts a video byte stream into payloads with two-byte payload headers
// ----------------------------------------------------------------------------
// The block takes one input beat per clock whenever its group queue has room
// (s_ready is simply "queue not full"): frame starts, loss reports and data
// bytes are all classified and booked in the cycle they are accepted. A data
// byte that opens a payload yields three result beats (header length, header
// flags, data byte), any other data byte one beat, and an abandoned frame one
// beat with m_frame_abandoned set; frame starts, loss reports and swallowed
// bytes yield none. The result channel moves one beat per cycle, so with the
// consumer always ready the sustained rate is one input beat per cycle except
// at payload openings, which add two header beats. An item's first result
// beat passes the group queue and the output register before m_valid shows
// it. Configuration writes (request_size, max_payload, drop_lossy) are
// always taken and act at once; they belong between frames or while idle.
module video_payload_packetizer #(
    parameter int SERIAL_BITS = vpp_pkg::SERIAL_BITS_DEF,
    parameter int LENGTH_BITS = vpp_pkg::LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = vpp_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vpp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vpp_pkg::CFG_DATA_W-1:0] cfg_data,

    // input item channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [vpp_pkg::OPCODE_W-1:0]  s_opcode,
    input  logic [vpp_pkg::FLEN_W-1:0]    s_frame_length,
    input  logic [vpp_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic [vpp_pkg::TAG_W-1:0]     s_loss_tag,

    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [vpp_pkg::BYTE_W-1:0]    m_out_byte,
    output logic                          m_request_first,
    output logic                          m_request_end,
    output logic                          m_payload_full,
    output logic [vpp_pkg::TAG_W-1:0]     m_frame_tag,
    output logic                          m_request_discard,
    output logic                          m_frame_abandoned,
    output logic                          m_last_of_run
);

    vpp_pkg::cfg_t   cfg_reg, cfg_next;
    vpp_pkg::group_t push_grp;
    vpp_pkg::group_t head_grp;
    logic            item_accept;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    // config writes never stall
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                vpp_pkg::REG_REQUEST_SIZE: cfg_next.request_size = cfg_data[vpp_pkg::REQ_W-1:0];
                vpp_pkg::REG_MAX_PAYLOAD:  cfg_next.max_payload  = cfg_data;
                vpp_pkg::REG_DROP_LOSSY:   cfg_next.drop_lossy   = cfg_data[0];
                default: begin
                    // unused index, write is dropped
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.request_size <= vpp_pkg::REQUEST_SIZE_RST;
            cfg_reg.max_payload  <= vpp_pkg::MAX_PAYLOAD_RST;
            cfg_reg.drop_lossy   <= vpp_pkg::DROP_LOSSY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front end books every beat; a group only goes out if it has results
    assign s_ready     = !q_full;
    assign item_accept = s_valid && s_ready;

    vpp_front #(
        .SERIAL_BITS (SERIAL_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .item_accept       (item_accept),
        .item_opcode       (s_opcode),
        .item_frame_length (s_frame_length),
        .item_data_byte    (s_data_byte),
        .item_loss_tag     (s_loss_tag),
        .push              (push),
        .grp               (push_grp)
    );

    // decouples booking from beat expansion so header beats do not stall intake until the queue fills
    vpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_grp (push_grp),
        .pop      (pop),
        .head_grp (head_grp),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back end expands groups into header and data beats
    vpp_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head_grp          (head_grp),
        .empty             (q_empty),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_request_first   (m_request_first),
        .m_request_end     (m_request_end),
        .m_payload_full    (m_payload_full),
        .m_frame_tag       (m_frame_tag),
        .m_request_discard (m_request_discard),
        .m_frame_abandoned (m_frame_abandoned),
        .m_last_of_run     (m_last_of_run)
    );

endmodule

[rtl/core/vpp_front.sv]
// ----------------------------------------------------------------------------
// vpp_front
// frame and request bookkeeping; turns each input item into a beat group
// ----------------------------------------------------------------------------
module vpp_front #(
    parameter int SERIAL_BITS = vpp_pkg::SERIAL_BITS_DEF,
    parameter int LENGTH_BITS = vpp_pkg::LENGTH_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  vpp_pkg::cfg_t                 cfg,
    input  logic                          item_accept,
    input  logic [vpp_pkg::OPCODE_W-1:0]  item_opcode,
    input  logic [vpp_pkg::FLEN_W-1:0]    item_frame_length,
    input  logic [vpp_pkg::BYTE_W-1:0]    item_data_byte,
    input  logic [vpp_pkg::TAG_W-1:0]     item_loss_tag,
    output logic                          push,
    output vpp_pkg::group_t               grp
);

    logic                            frame_toggle_reg, frame_toggle_next;
    logic [SERIAL_BITS-1:0]          frame_serial_reg, frame_serial_next;
    logic                            frame_lost_reg, frame_lost_next;
    logic [LENGTH_BITS-1:0]          bytes_left_reg, bytes_left_next;
    logic [vpp_pkg::REQ_W-1:0]       request_fill_reg, request_fill_next;
    logic [vpp_pkg::PAYLOAD_W-1:0]   payload_fill_reg, payload_fill_next;
    logic                            skipping_reg, skipping_next;

    logic [SERIAL_BITS+7:0]                 serial_ext;
    logic [vpp_pkg::TAG_W-1:0]              tag;
    logic [LENGTH_BITS+vpp_pkg::FLEN_W-1:0] len_ext;
    logic [LENGTH_BITS-1:0]                 len;
    logic                                   isoc;
    logic                                   rf_zero;
    logic                                   drop_cond;
    logic                                   hdr;
    logic [vpp_pkg::PAYLOAD_W-1:0]          cap;
    logic [vpp_pkg::PAYLOAD_W-1:0]          room;
    logic                                   eof;
    logic [vpp_pkg::BYTE_W-1:0]             flags;
    logic [vpp_pkg::REQ_W-1:0]              rf_base;
    logic [vpp_pkg::REQ_W:0]                rf_new;
    logic [vpp_pkg::PAYLOAD_W-1:0]          pf_base;
    logic [vpp_pkg::PAYLOAD_W:0]            pf_new;
    logic [LENGTH_BITS-1:0]                 bl_dec;
    logic                                   bl_zero;
    logic                                   full;
    logic                                   req_end;

    assign serial_ext = {8'd0, frame_serial_reg};
    assign tag        = serial_ext[7:0];
    assign len_ext    = {{LENGTH_BITS{1'b0}}, item_frame_length};
    assign len        = len_ext[LENGTH_BITS-1:0];

    assign isoc      = (cfg.max_payload == '0);
    assign rf_zero   = (request_fill_reg == '0);
    assign drop_cond = isoc && cfg.drop_lossy && frame_lost_reg;
    assign hdr       = rf_zero && (isoc || payload_fill_reg == '0);

    // end of frame flag: remaining bytes fit in what is left after the header
    assign cap  = isoc ? {5'd0, cfg.request_size} : cfg.max_payload;
    assign room = (cap > vpp_pkg::PAYLOAD_W'(2)) ? cap - vpp_pkg::PAYLOAD_W'(2)
                                                 : vpp_pkg::PAYLOAD_W'(1);
    assign eof  = ({{vpp_pkg::PAYLOAD_W{1'b0}}, bytes_left_reg}
                   <= {{LENGTH_BITS{1'b0}}, room});
    assign flags = vpp_pkg::HDR_EOH
                 | {7'd0, frame_toggle_reg}
                 | (frame_lost_reg ? vpp_pkg::HDR_ERR : 8'd0)
                 | (eof ? vpp_pkg::HDR_EOF : 8'd0);

    assign rf_base = hdr ? 16'd2 : request_fill_reg;
    assign rf_new  = {1'b0, rf_base} + 17'd1;
    assign pf_base = (hdr && !isoc) ? 21'd2 : payload_fill_reg;
    assign pf_new  = isoc ? {1'b0, pf_base} : {1'b0, pf_base} + 22'd1;
    assign bl_dec  = bytes_left_reg - LENGTH_BITS'(1);
    assign bl_zero = (bl_dec == '0);
    assign full    = !isoc && (pf_new >= {1'b0, cfg.max_payload});
    assign req_end = (rf_new >= {1'b0, cfg.request_size}) || bl_zero || full;

    always_comb begin
        frame_toggle_next = frame_toggle_reg;
        frame_serial_next = frame_serial_reg;
        frame_lost_next   = frame_lost_reg;
        bytes_left_next   = bytes_left_reg;
        request_fill_next = request_fill_reg;
        payload_fill_next = payload_fill_reg;
        skipping_next     = skipping_reg;
        push              = 1'b0;
        grp               = '0;
        grp.tag           = tag;
        if (item_accept) begin
            unique case (item_opcode)
                vpp_pkg::OP_FRAME_START: begin
                    if (bytes_left_reg == '0 && len != '0) begin
                        bytes_left_next = len;
                        skipping_next   = 1'b0;
                    end
                end
                vpp_pkg::OP_LOSS: begin
                    if (item_loss_tag == tag) begin
                        frame_lost_next = 1'b1;
                    end
                end
                vpp_pkg::OP_DATA: begin
                    if (bytes_left_reg != '0) begin
                        bytes_left_next = bl_dec;
                        if (skipping_reg) begin
                            // swallowing the rest of an abandoned frame
                            if (bl_zero) begin
                                skipping_next = 1'b0;
                            end
                        end else if (rf_zero && drop_cond) begin
                            // abandon at request start
                            frame_toggle_next = ~frame_toggle_reg;
                            frame_serial_next = frame_serial_reg + SERIAL_BITS'(1);
                            frame_lost_next   = 1'b0;
                            skipping_next     = !bl_zero;
                            push              = 1'b1;
                            grp.aband         = 1'b1;
                        end else begin
                            push          = 1'b1;
                            grp.hdr       = hdr;
                            grp.hdr_flags = flags;
                            grp.data      = item_data_byte;
                            grp.first     = rf_zero && !hdr;
                            grp.last      = req_end;
                            grp.full      = full;
                            if (req_end) begin
                                if (drop_cond) begin
                                    // abandon at request end
                                    grp.discard       = 1'b1;
                                    grp.aband         = 1'b1;
                                    frame_toggle_next = ~frame_toggle_reg;
                                    frame_serial_next = frame_serial_reg + SERIAL_BITS'(1);
                                    frame_lost_next   = 1'b0;
                                    skipping_next     = !bl_zero;
                                end else if (bl_zero) begin
                                    frame_toggle_next = ~frame_toggle_reg;
                                    frame_serial_next = frame_serial_reg + SERIAL_BITS'(1);
                                    frame_lost_next   = 1'b0;
                                end
                                payload_fill_next = (isoc || full || bl_zero)
                                                    ? '0 : pf_new[vpp_pkg::PAYLOAD_W-1:0];
                                request_fill_next = '0;
                            end else begin
                                request_fill_next = rf_new[vpp_pkg::REQ_W-1:0];
                                payload_fill_next = pf_new[vpp_pkg::PAYLOAD_W-1:0];
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_toggle_reg <= 1'b0;
            frame_serial_reg <= '0;
            frame_lost_reg   <= 1'b0;
            bytes_left_reg   <= '0;
            request_fill_reg <= '0;
            payload_fill_reg <= '0;
            skipping_reg     <= 1'b0;
        end else begin
            frame_toggle_reg <= frame_toggle_next;
            frame_serial_reg <= frame_serial_next;
            frame_lost_reg   <= frame_lost_next;
            bytes_left_reg   <= bytes_left_next;
            request_fill_reg <= request_fill_next;
            payload_fill_reg <= payload_fill_next;
            skipping_reg     <= skipping_next;
        end
    end

endmodule

[rtl/core/vpp_queue.sv]
// ----------------------------------------------------------------------------
// vpp_queue
// short register queue of beat groups between front and back end
// ----------------------------------------------------------------------------
`include "video_payload_packetizer_defines.svh"

module vpp_queue #(
    parameter int DEPTH = vpp_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  vpp_pkg::group_t push_grp,
    input  logic            pop,
    output vpp_pkg::group_t head_grp,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vpp_pkg::group_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_grp = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_grp;
        end
    end

    `VPP_ASSERT(a_no_push_when_full, aclk, aresetn, push, !full, "group pushed into full queue")
    `VPP_ASSERT(a_no_pop_when_empty, aclk, aresetn, pop, !empty, "group popped from empty queue")
    `VPP_ASSERT_NEXT(a_count_rises, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + CNT_W'(1), "queue count lost a push")

endmodule

[rtl/core/vpp_back.sv]
// ----------------------------------------------------------------------------
// vpp_back
// expands each beat group into header and data beats on the result channel
// ----------------------------------------------------------------------------
module vpp_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  vpp_pkg::group_t             head_grp,
    input  logic                        empty,
    output logic                        pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [vpp_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                        m_request_first,
    output logic                        m_request_end,
    output logic                        m_payload_full,
    output logic [vpp_pkg::TAG_W-1:0]   m_frame_tag,
    output logic                        m_request_discard,
    output logic                        m_frame_abandoned,
    output logic                        m_last_of_run
);

    vpp_pkg::beat_t             beat_reg, beat_next;
    logic                       valid_reg, valid_next;
    logic                       load;
    logic [vpp_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                       first_reg, first_next;
    logic                       end_reg, end_next;
    logic                       full_reg, full_next;
    logic [vpp_pkg::TAG_W-1:0]  tag_reg, tag_next;
    logic                       discard_reg, discard_next;
    logic                       aband_reg, aband_next;
    logic                       last_reg, last_next;

    // output register frees whenever the current beat is taken
    assign load = !empty && (!valid_reg || m_ready);

    always_comb begin
        beat_next    = beat_reg;
        pop          = 1'b0;
        valid_next   = (valid_reg && !m_ready) || load;
        byte_next    = byte_reg;
        first_next   = first_reg;
        end_next     = end_reg;
        full_next    = full_reg;
        tag_next     = tag_reg;
        discard_next = discard_reg;
        aband_next   = aband_reg;
        last_next    = last_reg;
        if (load) begin
            byte_next    = head_grp.data;
            first_next   = head_grp.first;
            end_next     = head_grp.last;
            full_next    = head_grp.full;
            tag_next     = head_grp.tag;
            discard_next = head_grp.discard;
            aband_next   = head_grp.aband;
            last_next    = 1'b1;
            unique case (beat_reg)
                vpp_pkg::BEAT_HDR_LEN: begin
                    if (head_grp.hdr) begin
                        byte_next    = vpp_pkg::HDR_LEN;
                        first_next   = 1'b1;
                        end_next     = 1'b0;
                        full_next    = 1'b0;
                        discard_next = 1'b0;
                        aband_next   = 1'b0;
                        last_next    = 1'b0;
                        beat_next    = vpp_pkg::BEAT_HDR_FLAGS;
                    end else begin
                        pop = 1'b1;
                    end
                end
                vpp_pkg::BEAT_HDR_FLAGS: begin
                    byte_next    = head_grp.hdr_flags;
                    first_next   = 1'b0;
                    end_next     = 1'b0;
                    full_next    = 1'b0;
                    discard_next = 1'b0;
                    aband_next   = 1'b0;
                    last_next    = 1'b0;
                    beat_next    = vpp_pkg::BEAT_DATA;
                end
                vpp_pkg::BEAT_DATA: begin
                    pop       = 1'b1;
                    beat_next = vpp_pkg::BEAT_HDR_LEN;
                end
                default: begin
                    beat_next = vpp_pkg::BEAT_HDR_LEN;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg  <= vpp_pkg::BEAT_HDR_LEN;
            valid_reg <= 1'b0;
        end else begin
            beat_reg  <= beat_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        first_reg   <= first_next;
        end_reg     <= end_next;
        full_reg    <= full_next;
        tag_reg     <= tag_next;
        discard_reg <= discard_next;
        aband_reg   <= aband_next;
        last_reg    <= last_next;
    end

    assign m_valid           = valid_reg;
    assign m_out_byte        = byte_reg;
    assign m_request_first   = first_reg;
    assign m_request_end     = end_reg;
    assign m_payload_full    = full_reg;
    assign m_frame_tag       = tag_reg;
    assign m_request_discard = discard_reg;
    assign m_frame_abandoned = aband_reg;
    assign m_last_of_run     = last_reg;

endmodule
